// ===== rtl/core/mspg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers of the step pulse generator.
// No dependencies.
package mspg_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int AXES            = 4;   // axes that count for length and pulses
  localparam int AXES_IN         = 4;   // axis fields carried per segment
  localparam int SPEED_FRAC_BITS = 12;
  localparam int JF_BITS         = 12;

  localparam int CMD_W   = 2;
  localparam int DELTA_W = 16;
  localparam int SPD_W   = 20;
  localparam int JF_W    = 16;
  localparam int CFG_W   = 27;
  localparam int TB_W    = 27;
  localparam int PER_W   = 27;
  localparam int QC_W    = 4;
  localparam int REG_W   = 16;
  localparam int V_W     = SPD_W + SPEED_FRAC_BITS;
  localparam int PF_W    = SPEED_FRAC_BITS + 1;
  localparam int SQ_IN_W = V_W - SPEED_FRAC_BITS + 4;
  localparam int SQ_W    = 2 * SQ_IN_W;
  localparam int DIV_NW  = TB_W + 2 * SPEED_FRAC_BITS;
  localparam int DIV_DW  = V_W;
  localparam int BRK_W   = 43;
  localparam int SEG_W   = AXES_IN * DELTA_W + 2 * SPD_W + JF_W;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

  localparam logic [1:0] REG_ACCEL     = 2'd0;
  localparam logic [1:0] REG_MIN_SPEED = 2'd1;
  localparam logic [1:0] REG_MAX_INC   = 2'd2;
  localparam logic [1:0] REG_TICK_BASE = 2'd3;

  localparam logic [REG_W-1:0] ACCEL_RST     = 16'd1;
  localparam logic [REG_W-1:0] MIN_SPEED_RST = 16'd2;
  localparam logic [REG_W-1:0] MAX_INC_RST   = 16'd500;
  localparam logic [TB_W-1:0]  TICK_BASE_RST = 27'(10 * 1000 * 1000);

  localparam logic [PER_W-1:0] PERIOD_MAX = '1;
  localparam logic signed [BRK_W-1:0] STOP_MARGIN = 43'sd4;

  typedef struct packed {
    logic latch;
    logic simple;
    logic rd_head;
    logic sq;
    logic brk_start;
    logic brk_take;
    logic aov_start;
    logic upd;
    logic per_start;
    logic fin;
    logic jmul;
    logic jsat;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_step;
    logic div_done;
    logic need_aov;
    logic v_zero;
    logic jct;
    logic out_free;
  } dp_sts_t;

  function automatic logic [DELTA_W-1:0] mag(input logic [DELTA_W-1:0] d);
    return d[DELTA_W-1] ? (~d + 16'd1) : d;
  endfunction

  function automatic logic [DELTA_W-1:0] seg_len(input logic [AXES_IN*DELTA_W-1:0] dl);
    logic [DELTA_W-1:0] m;
    logic [DELTA_W-1:0] a;
    m = '0;
    for (int k = 0; k < AXES; k++) begin
      a = mag(dl[DELTA_W*k +: DELTA_W]);
      if (a > m) m = a;
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/mspg_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for segment commands and step results.
// Depends on mspg_pkg.
interface mspg_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [mspg_pkg::CMD_W-1:0]            cmd;
  logic signed [mspg_pkg::DELTA_W-1:0]   delta_axis0;
  logic signed [mspg_pkg::DELTA_W-1:0]   delta_axis1;
  logic signed [mspg_pkg::DELTA_W-1:0]   delta_axis2;
  logic signed [mspg_pkg::DELTA_W-1:0]   delta_axis3;
  logic [mspg_pkg::SPD_W-1:0]            start_speed;
  logic [mspg_pkg::SPD_W-1:0]            cruise_speed;
  logic [mspg_pkg::SPD_W-1:0]            end_speed;
  logic [mspg_pkg::JF_W-1:0]             junction_factor;
  modport source (output valid, cmd, delta_axis0, delta_axis1, delta_axis2, delta_axis3,
                  start_speed, cruise_speed, end_speed, junction_factor, input ready);
  modport sink (input valid, cmd, delta_axis0, delta_axis1, delta_axis2, delta_axis3,
                start_speed, cruise_speed, end_speed, junction_factor, output ready);
endinterface

interface mspg_out_if;
  logic                        valid;
  logic                        ready;
  logic [3:0]                  pulse_mask;
  logic [3:0]                  dir_mask;
  logic [mspg_pkg::PER_W-1:0]  period_ticks;
  logic                        busy_res;
  logic                        segment_done;
  logic                        rejected;
  logic [mspg_pkg::QC_W-1:0]   queue_count;
  modport source (output valid, pulse_mask, dir_mask, period_ticks, busy_res,
                  segment_done, rejected, queue_count, input ready);
  modport sink (input valid, pulse_mask, dir_mask, period_ticks, busy_res,
                segment_done, rejected, queue_count, output ready);
endinterface

// ===== rtl/core/mspg_ram.sv =====
`timescale 1ns / 1ps
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
module mspg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/mspg_div.sv =====
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on mspg_pkg.
module mspg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mspg_pkg::DIV_NW-1:0]   dividend,
  input  logic [mspg_pkg::DIV_DW-1:0]   divisor,
  output logic                          done,
  output logic [mspg_pkg::DIV_NW-1:0]   quotient
);
  localparam int NW = mspg_pkg::DIV_NW;
  localparam int DW = mspg_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] dsr_r;
  logic [NW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW:0]   sh;
  logic          ge;

  assign sh = {rem_r, quo_r[NW-1]};
  assign ge = sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NW);
        rem_r <= '0;
        quo_r <= dividend;
        dsr_r <= divisor;
      end else if (run_r) begin
        rem_r <= ge ? DW'(sh - {1'b0, dsr_r}) : DW'(sh);
        quo_r <= {quo_r[NW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

// ===== rtl/core/mspg_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the step pulse generator: walks one command through the datapath.
// Depends on mspg_pkg.
module mspg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mspg_pkg::dp_sts_t sts,
  output mspg_pkg::dp_cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_BRK  = 4'd3;
  localparam logic [3:0] S_BRKW = 4'd4;
  localparam logic [3:0] S_AOV  = 4'd5;
  localparam logic [3:0] S_AOVW = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_PER  = 4'd8;
  localparam logic [3:0] S_PERW = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_JRD  = 4'd11;
  localparam logic [3:0] S_JMUL = 4'd12;
  localparam logic [3:0] S_JSAT = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_step) begin
          cmd.rd_head = 1'b1;
          state_nxt   = S_SQ;
        end else begin
          cmd.simple = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_BRK;
      end
      S_BRK: begin
        cmd.brk_start = 1'b1;
        state_nxt     = S_BRKW;
      end
      S_BRKW: begin
        if (sts.div_done) begin
          cmd.brk_take = 1'b1;
          state_nxt    = S_AOV;
        end
      end
      S_AOV: begin
        if (sts.need_aov && !sts.v_zero) begin
          cmd.aov_start = 1'b1;
          state_nxt     = S_AOVW;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_AOVW: if (sts.div_done) state_nxt = S_UPD;
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_PER;
      end
      S_PER: begin
        if (!sts.v_zero) begin
          cmd.per_start = 1'b1;
          state_nxt     = S_PERW;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PERW: if (sts.div_done) state_nxt = S_FIN;
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = sts.jct ? S_JRD : S_OUT;
      end
      S_JRD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_JMUL;
      end
      S_JMUL: begin
        cmd.jmul  = 1'b1;
        state_nxt = S_JSAT;
      end
      S_JSAT: begin
        cmd.jsat  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

// ===== rtl/core/mspg_dp.sv =====
`timescale 1ns / 1ps
// Datapath: segment queue, speed profile, Bresenham accumulators, period, result.
// Depends on mspg_pkg, mspg_ram, mspg_div.
module mspg_dp #(
  parameter int QUEUE_DEPTH = mspg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mspg_pkg::dp_cmd_t                   cmd,
  output mspg_pkg::dp_sts_t                   sts,
  input  logic [mspg_pkg::CMD_W-1:0]          in_cmd,
  input  logic [mspg_pkg::AXES_IN*mspg_pkg::DELTA_W-1:0] in_deltas,
  input  logic [mspg_pkg::SPD_W-1:0]          in_start,
  input  logic [mspg_pkg::SPD_W-1:0]          in_cruise,
  input  logic [mspg_pkg::SPD_W-1:0]          in_end,
  input  logic [mspg_pkg::JF_W-1:0]           in_jf,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [mspg_pkg::CFG_W-1:0]          cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [3:0]                          out_pulse,
  output logic [3:0]                          out_dir,
  output logic [mspg_pkg::PER_W-1:0]          out_period,
  output logic                                out_busy,
  output logic                                out_done,
  output logic                                out_rej,
  output logic [mspg_pkg::QC_W-1:0]           out_count
);
  localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int F    = mspg_pkg::SPEED_FRAC_BITS;
  localparam int V_W  = mspg_pkg::V_W;
  localparam int DW   = mspg_pkg::DELTA_W;
  localparam int SW   = mspg_pkg::SPD_W;
  localparam int NW   = mspg_pkg::DIV_NW;
  localparam int PW   = mspg_pkg::PER_W;
  localparam int PFW  = mspg_pkg::PF_W;
  localparam int BW   = mspg_pkg::BRK_W;
  localparam int SQW  = mspg_pkg::SQ_W;
  localparam int DLW  = mspg_pkg::AXES_IN * DW;
  localparam int ACW  = DW + 1;
  localparam int PRW  = V_W + mspg_pkg::JF_W;
  localparam int NA   = mspg_pkg::AXES_IN;

  // configuration
  logic [mspg_pkg::REG_W-1:0] accel_r, min_speed_r, max_inc_r;
  logic [mspg_pkg::TB_W-1:0]  tick_r;

  // latched item
  logic [mspg_pkg::CMD_W-1:0] icmd_r;
  logic [DLW-1:0]             idl_r;
  logic [SW-1:0]              istart_r, icruise_r, iend_r;
  logic [mspg_pkg::JF_W-1:0]  ijf_r;

  // queue and motion state
  logic [AW-1:0]   head_r, tail_r;
  logic [CW-1:0]   fill_r;
  logic [V_W-1:0]  v_r;
  logic [DW-1:0]   sidx_r;
  logic [ACW-1:0]  acc_r [NA];
  logic [PFW-1:0]  pf_r;
  logic [3:0]      dir_r;

  // running segment
  logic [DLW-1:0]  sdl_r;
  logic [DW-1:0]   steps_r;
  logic [SW-1:0]   cruise_r, end_r;
  logic [SQW-1:0]  sq1_r, sq2_r;
  logic            num_neg_r, decel_r, accf_r;
  logic [PRW-1:0]  prod_r;

  // result
  logic [3:0]      rpulse_r;
  logic [PW-1:0]   rperiod_r;
  logic            rbusy_r, rdone_r, rrej_r;
  logic            ovalid_r;

  // memory
  logic            ram_we;
  logic [mspg_pkg::SEG_W-1:0] ram_wdata, ram_rdata;
  logic [DLW-1:0]  rd_dl;
  logic [SW-1:0]   rd_cruise, rd_end;
  logic [mspg_pkg::JF_W-1:0] rd_jf;

  // divider
  logic            div_start, div_done;
  logic [NW-1:0]   div_n, div_q;
  logic [mspg_pkg::DIV_DW-1:0] div_d;

  logic [DW-1:0]   load_len;
  logic            load_ok;
  logic [AW-1:0]   head_inc, tail_inc;
  logic            v_zero;
  logic [mspg_pkg::REG_W-1:0] accel_eff;
  logic signed [BW-1:0] brk_s, rem_s, diff_s;
  logic [NW-1:0]   q_eff, cap_q;
  logic [V_W-1:0]  floor_q, end_q, cruise_q, dec_v, upd_v;
  logic [V_W:0]    acc_sum;
  logic [PFW-1:0]  pf_sum, pf_fin;
  logic [NW-F:0]   per_i;
  logic [PW-1:0]   per_fin;
  logic [ACW:0]    a_sum [NA];
  logic [ACW-1:0]  acc_fin [NA];
  logic [3:0]      pulse_fin;
  logic [DW:0]     sidx_inc;
  logic            done_now;

  assign head_inc = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign load_len = mspg_pkg::seg_len(idl_r);
  assign load_ok  = (fill_r < CW'(QUEUE_DEPTH)) && (load_len != '0);
  assign ram_we   = cmd.simple && (icmd_r == mspg_pkg::CMD_LOAD) && load_ok;
  assign ram_wdata = {ijf_r, iend_r, icruise_r, idl_r};
  assign rd_dl     = ram_rdata[DLW-1:0];
  assign rd_cruise = ram_rdata[DLW +: SW];
  assign rd_end    = ram_rdata[DLW+SW +: SW];
  assign rd_jf     = ram_rdata[DLW+2*SW +: mspg_pkg::JF_W];

  mspg_ram #(.WIDTH(mspg_pkg::SEG_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_r),
    .wdata(ram_wdata),
    .re   (cmd.rd_head),
    .raddr(head_r),
    .rdata(ram_rdata)
  );

  // operand select for the shared divider
  assign v_zero    = (v_r == '0);
  assign accel_eff = (accel_r == '0) ? 16'd1 : accel_r;
  assign div_start = cmd.brk_start | cmd.aov_start | cmd.per_start;

  always_comb begin
    if (cmd.brk_start) begin
      div_n = NW'({sq1_r < sq2_r ? (sq2_r - sq1_r) : (sq1_r - sq2_r)});
      div_d = mspg_pkg::DIV_DW'({accel_eff, 9'b0});
    end else if (cmd.aov_start) begin
      div_n = NW'({accel_r, {(2*F){1'b0}}});
      div_d = v_r;
    end else begin
      div_n = {tick_r, {(2*F){1'b0}}};
      div_d = v_r;
    end
  end

  mspg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_n),
    .divisor (div_d),
    .done    (div_done),
    .quotient(div_q)
  );

  // braking decision: remaining - (v^2 - end^2)/(2*accel) < margin
  always_comb begin
    brk_s  = num_neg_r ? -$signed(BW'(div_q)) : $signed(BW'(div_q));
    rem_s  = $signed(BW'(steps_r)) - $signed(BW'(sidx_r));
    diff_s = rem_s - brk_s;
  end

  // speed update
  always_comb begin
    q_eff    = v_zero ? '1 : div_q;
    floor_q  = V_W'({min_speed_r, {F{1'b0}}});
    end_q    = {end_r, {F{1'b0}}};
    cruise_q = {cruise_r, {F{1'b0}}};
    cap_q    = NW'({max_inc_r, {F{1'b0}}});
    dec_v    = (NW'(v_r) > q_eff) ? (v_r - V_W'(q_eff)) : '0;
    if (dec_v < floor_q) dec_v = floor_q;
    if (dec_v < end_q)   dec_v = end_q;
    acc_sum  = (V_W+1)'(v_r) + (V_W+1)'((q_eff > cap_q) ? cap_q : q_eff);
    if (acc_sum > (V_W+1)'(cruise_q)) acc_sum = (V_W+1)'(cruise_q);
    if (decel_r)     upd_v = dec_v;
    else if (accf_r) upd_v = V_W'(acc_sum);
    else             upd_v = v_r;
  end

  // period, fraction carry, accumulators
  always_comb begin
    pf_sum = pf_r + PFW'(div_q[F-1:0]);
    if (pf_sum > {1'b1, {F{1'b0}}}) begin
      pf_fin = pf_sum - {1'b1, {F{1'b0}}};
      per_i  = (NW-F+1)'(div_q[NW-1:F]) + 1'b1;
    end else begin
      pf_fin = pf_sum;
      per_i  = (NW-F+1)'(div_q[NW-1:F]);
    end
    if (v_zero) begin
      per_fin = mspg_pkg::PERIOD_MAX;
      pf_fin  = pf_r;
    end else if (per_i > (NW-F+1)'(mspg_pkg::PERIOD_MAX)) begin
      per_fin = mspg_pkg::PERIOD_MAX;
    end else begin
      per_fin = PW'(per_i);
    end
    pulse_fin = '0;
    for (int k = 0; k < NA; k++) begin
      a_sum[k]   = (ACW+1)'(acc_r[k]) + (ACW+1)'(mspg_pkg::mag(sdl_r[DW*k +: DW]));
      acc_fin[k] = acc_r[k];
      if (k < mspg_pkg::AXES) begin
        if (a_sum[k] >= (ACW+1)'(steps_r)) begin
          a_sum[k]     = a_sum[k] - (ACW+1)'(steps_r);
          pulse_fin[k] = 1'b1;
        end
        acc_fin[k] = ACW'(a_sum[k]);
      end
    end
    sidx_inc = (DW+1)'(sidx_r) + 1'b1;
    done_now = sidx_inc >= (DW+1)'(steps_r);
  end

  assign sts.is_step  = (icmd_r == mspg_pkg::CMD_STEP) && (fill_r != '0);
  assign sts.div_done = div_done;
  assign sts.need_aov = decel_r | accf_r;
  assign sts.v_zero   = v_zero;
  assign sts.jct      = done_now && (fill_r > CW'(1));
  assign sts.out_free = !ovalid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r     <= mspg_pkg::ACCEL_RST;
      min_speed_r <= mspg_pkg::MIN_SPEED_RST;
      max_inc_r   <= mspg_pkg::MAX_INC_RST;
      tick_r      <= mspg_pkg::TICK_BASE_RST;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      v_r         <= '0;
      sidx_r      <= '0;
      pf_r        <= '0;
      dir_r       <= '0;
      ovalid_r    <= 1'b0;
      for (int k = 0; k < NA; k++) acc_r[k] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mspg_pkg::REG_ACCEL:     accel_r     <= cfg_data[mspg_pkg::REG_W-1:0];
          mspg_pkg::REG_MIN_SPEED: min_speed_r <= cfg_data[mspg_pkg::REG_W-1:0];
          mspg_pkg::REG_MAX_INC:   max_inc_r   <= cfg_data[mspg_pkg::REG_W-1:0];
          mspg_pkg::REG_TICK_BASE: tick_r      <= cfg_data[mspg_pkg::TB_W-1:0];
          default: ;
        endcase
      end

      if (cmd.simple) begin
        unique case (icmd_r)
          mspg_pkg::CMD_LOAD: begin
            if (load_ok) begin
              tail_r <= tail_inc;
              fill_r <= fill_r + 1'b1;
              if (fill_r == '0) begin
                v_r    <= {istart_r, {F{1'b0}}};
                sidx_r <= '0;
              end
            end
          end
          mspg_pkg::CMD_STOP: begin
            head_r <= '0;
            tail_r <= '0;
            fill_r <= '0;
            v_r    <= '0;
            sidx_r <= '0;
            pf_r   <= '0;
            dir_r  <= '0;
            for (int k = 0; k < NA; k++) acc_r[k] <= '0;
          end
          default: ;
        endcase
      end

      if (cmd.sq && sidx_r == '0) begin
        for (int k = 0; k < 4; k++)
          dir_r[k] <= (k < mspg_pkg::AXES) && (k < NA) ? rd_dl[DW*k + DW - 1] : 1'b0;
      end

      if (cmd.upd) v_r <= upd_v;

      if (cmd.fin) begin
        pf_r <= pf_fin;
        if (done_now) begin
          sidx_r <= '0;
          head_r <= head_inc;
          fill_r <= fill_r - 1'b1;
          for (int k = 0; k < NA; k++) acc_r[k] <= '0;
        end else begin
          sidx_r <= DW'(sidx_inc);
          for (int k = 0; k < NA; k++) acc_r[k] <= acc_fin[k];
        end
      end

      if (cmd.jsat)
        v_r <= (prod_r[PRW-1:V_W+mspg_pkg::JF_BITS] != '0) ? '1
             : prod_r[V_W+mspg_pkg::JF_BITS-1:mspg_pkg::JF_BITS];

      if (cmd.out_load)      ovalid_r <= 1'b1;
      else if (out_ready)    ovalid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      icmd_r    <= in_cmd;
      idl_r     <= in_deltas;
      istart_r  <= in_start;
      icruise_r <= in_cruise;
      iend_r    <= in_end;
      ijf_r     <= in_jf;
    end
    if (cmd.sq) begin
      sdl_r    <= rd_dl;
      steps_r  <= mspg_pkg::seg_len(rd_dl);
      cruise_r <= rd_cruise;
      end_r    <= rd_end;
      sq1_r    <= v_r[V_W-1:F-4] * v_r[V_W-1:F-4];
      sq2_r    <= {rd_end, 4'b0} * {rd_end, 4'b0};
    end
    if (cmd.brk_start) num_neg_r <= sq1_r < sq2_r;
    if (cmd.brk_take) begin
      decel_r <= diff_s < mspg_pkg::STOP_MARGIN;
      accf_r  <= v_r[V_W-1:F] < cruise_r;
    end
    if (cmd.jmul) prod_r <= v_r * rd_jf;
    if (cmd.simple) begin
      rpulse_r  <= '0;
      rperiod_r <= '0;
      rbusy_r   <= 1'b0;
      rdone_r   <= 1'b0;
      rrej_r    <= (icmd_r == mspg_pkg::CMD_LOAD) && !load_ok;
    end
    if (cmd.fin) begin
      rpulse_r  <= pulse_fin;
      rperiod_r <= per_fin;
      rbusy_r   <= 1'b1;
      rdone_r   <= done_now;
      rrej_r    <= 1'b0;
    end
    if (cmd.out_load) begin
      out_pulse  <= rpulse_r;
      out_dir    <= dir_r;
      out_period <= rperiod_r;
      out_busy   <= rbusy_r;
      out_done   <= rdone_r;
      out_rej    <= rrej_r;
      out_count  <= mspg_pkg::QC_W'(fill_r);
    end
  end

  assign out_valid = ovalid_r;
endmodule

// ===== rtl/core/multi_axis_step_pulse_generator_top.sv =====
`timescale 1ns / 1ps
// Load, stop and idle commands pass from acceptance through the dispatch and output
// states to their result beat. A step beat adds the square, braking, speed update,
// period and finish states, with up to three passes through the shared radix-2 divider
// (braking distance, accel/v, tick_base/v); a segment handover adds the junction states.
// accel/v is skipped when the speed holds or is zero, tick_base/v only when it is zero.
// Throughput: one command at a time; a new beat is taken while the last result waits.
// Reset: synchronous, active low rst_n; queue, speed and registers return to defaults.
module multi_axis_step_pulse_generator_top #(
  parameter int QUEUE_DEPTH = mspg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mspg_in_if.sink                     in_ch,
  mspg_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [mspg_pkg::CFG_W-1:0]  cfg_data
);
  // Sequencer and datapath talk only through these two bundles.
  mspg_pkg::dp_cmd_t cmd;
  mspg_pkg::dp_sts_t sts;

  mspg_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // The datapath holds the segment queue (RAM), motion state, the divider
  // and the output register that decouples the result side.
  mspg_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_cmd    (in_ch.cmd),
    .in_deltas ({in_ch.delta_axis3, in_ch.delta_axis2, in_ch.delta_axis1,
                 in_ch.delta_axis0}),
    .in_start  (in_ch.start_speed),
    .in_cruise (in_ch.cruise_speed),
    .in_end    (in_ch.end_speed),
    .in_jf     (in_ch.junction_factor),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pulse (out_ch.pulse_mask),
    .out_dir   (out_ch.dir_mask),
    .out_period(out_ch.period_ticks),
    .out_busy  (out_ch.busy_res),
    .out_done  (out_ch.segment_done),
    .out_rej   (out_ch.rejected),
    .out_count (out_ch.queue_count)
  );
endmodule

// ===== rtl/core/mspg_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks of the step pulse generator, bound to the top level.
// Depends on multi_axis_step_pulse_generator_top.
module mspg_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [3:0] pulse_mask,
  input logic [26:0] period_ticks,
  input logic       busy_res,
  input logic       segment_done,
  input logic       rejected
);
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && segment_done |-> busy_res)
    else $error("segment done without a running segment");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> pulse_mask == 4'd0 && period_ticks == 27'd0)
    else $error("pulses or period on a non-step beat");

  a_reject_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rejected |-> !busy_res && !segment_done)
    else $error("rejected beat also reports a step");
endmodule

bind multi_axis_step_pulse_generator_top mspg_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .pulse_mask  (out_ch.pulse_mask),
  .period_ticks(out_ch.period_ticks),
  .busy_res    (out_ch.busy_res),
  .segment_done(out_ch.segment_done),
  .rejected    (out_ch.rejected)
);
